>>> rtl/core/swa_pkg.sv
// shared constants and types for the sequence window allocator
package swa_pkg;

  localparam int MAX_GROUPS = 8;
  localparam int MAX_QUEUES = 8;
  localparam int NUM_WIN    = MAX_GROUPS * MAX_QUEUES;
  localparam int WIN_AW     = $clog2(NUM_WIN);
  localparam int WIN_LEN    = 64;
  localparam int POS_W      = $clog2(WIN_LEN);
  localparam int CNT_W      = $clog2(WIN_LEN + 1);

  localparam logic [1:0] CMD_RESET   = 2'd0;
  localparam logic [1:0] CMD_APPLY   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_RETRY = 2'd2;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_GROUPS = 2'd1;
  localparam logic [1:0] CFG_QUEUES = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  group_index;
    logic [2:0]  queue_index;
    logic [63:0] seq_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] granted_number;
    logic [63:0] oldest_done;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        low;
    logic [63:0]        high;
    logic [WIN_LEN-1:0] marks;
  } win_entry_t;

  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
  } win_rd_t;

  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] addr;
    win_entry_t        data;
  } win_wr_t;

endpackage

>>> rtl/core/swa_win_store.sv
// window state memory with per-entry valid bits and write-to-read forwarding
module swa_win_store (
  input  logic                clk,
  input  logic                rst_n,
  input  swa_pkg::win_rd_t    rd,
  input  swa_pkg::win_wr_t    wr,
  output swa_pkg::win_entry_t rd_data
);
  import swa_pkg::*;

  win_entry_t         mem [NUM_WIN];
  win_entry_t         rd_raw_r;
  win_entry_t         fwd_data_r;
  logic [NUM_WIN-1:0] vld_r;
  logic               rd_vld_r;
  logic               fwd_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_raw_r   <= mem[rd.addr];
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld_r <= vld_r[rd.addr];
        // same entry written at this edge: take the new value
        fwd_r    <= wr.we && (wr.addr == rd.addr);
      end
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (rd_vld_r ? rd_raw_r : '0);

endmodule

>>> rtl/core/sequence_window_allocator_core.sv
// sequence window allocator: top level with command sequencer and config registers
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ------------------------------------
//  input     start, busy, in_item                item taken when start & !busy
//  result    out_valid, out_item                 one-cycle strobe, no back-pressure
//  config    psel penable pwrite paddr pwdata    apb write, pready always high
//            prdata pready
//
// an item passes through the calc state, which uses its window as read from the state
// memory and finds the run of finish marks, then the write-back state, which writes the
// window back; busy is high in calc only. the result is registered from write-back.
// reset is synchronous; windows read as zero until first written (valid bits).
// the receiver cannot stall, so results never wait.
module sequence_window_allocator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  swa_pkg::in_item_t  in_item,
  output logic               out_valid,
  output swa_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import swa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  logic [1:0] state_r, state_nxt;

  // config registers
  logic       en_r;
  logic [3:0] grp_cnt_r;
  logic [3:0] que_cnt_r;
  logic [1:0] cfg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 1'b1;
      grp_cnt_r <= 4'd8;
      que_cnt_r <= 4'd8;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_ENABLE: en_r      <= pwdata[0];
        CFG_GROUPS: grp_cnt_r <= pwdata[3:0];
        CFG_QUEUES: que_cnt_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_ENABLE: prdata = {31'd0, en_r};
      CFG_GROUPS: prdata = {28'd0, grp_cnt_r};
      CFG_QUEUES: prdata = {28'd0, que_cnt_r};
      default:    prdata = '0;
    endcase
  end

  // accept and decode
  logic       accept;
  logic       in_range;
  logic       known_cmd;
  logic [WIN_AW-1:0] in_widx;

  assign busy   = (state_r == S_CALC);
  assign accept = start && !busy;

  assign in_range = ({1'b0, in_item.group_index} < grp_cnt_r) &&
                    ({1'b0, in_item.queue_index} < que_cnt_r) &&
                    (int'(in_item.group_index) < MAX_GROUPS) &&
                    (int'(in_item.queue_index) < MAX_QUEUES);
  assign known_cmd = in_item.command inside {CMD_RESET, CMD_APPLY, CMD_RELEASE};
  assign in_widx = WIN_AW'(int'(in_item.group_index) * MAX_QUEUES +
                           int'(in_item.queue_index));

  in_item_t          item_r;
  logic [WIN_AW-1:0] widx_r;
  logic              act_r;
  logic              rng_err_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      widx_r <= in_widx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      rng_err_r <= 1'b0;
    end else if (accept) begin
      act_r     <= en_r && known_cmd && in_range;
      rng_err_r <= en_r && known_cmd && !in_range;
    end
  end

  // state memory
  win_rd_t    mem_rd;
  win_wr_t    mem_wr;
  win_entry_t ent;

  assign mem_rd.en   = accept;
  assign mem_rd.addr = in_widx;

  swa_win_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (mem_rd),
    .wr      (mem_wr),
    .rd_data (ent)
  );

  // calc stage: occupancy, rotated marks, run of finished numbers
  logic [63:0]          diff;
  logic [WIN_LEN-1:0]   mk_calc;
  logic [POS_W-1:0]     p0_calc;
  logic [2*WIN_LEN-1:0] rot_wide;
  logic [WIN_LEN-1:0]   rot;
  logic [CNT_W-1:0]     ones;

  assign diff    = ent.high - ent.low;
  assign mk_calc = (item_r.command == CMD_RELEASE) ?
                   (ent.marks | (WIN_LEN'(1) << item_r.seq_number[POS_W-1:0])) : ent.marks;
  assign p0_calc  = ent.low[POS_W-1:0] + POS_W'(1);
  assign rot_wide = {mk_calc, mk_calc} >> p0_calc;
  assign rot      = rot_wide[WIN_LEN-1:0];

  // trailing ones from the oldest outstanding slot
  always_comb begin
    ones = CNT_W'(WIN_LEN);
    for (int i = WIN_LEN - 1; i >= 0; i--) begin
      if (!rot[i]) begin
        ones = CNT_W'(i);
      end
    end
  end

  logic [63:0]        low_r;
  logic [63:0]        high_r;
  logic [WIN_LEN-1:0] mk_r;
  logic [POS_W-1:0]   p0_r;
  logic [CNT_W-1:0]   ones_r;
  logic [CNT_W-1:0]   diff_lo_r;
  logic               full_r;
  logic               lt_r;

  always_ff @(posedge clk) begin
    if (state_r == S_CALC) begin
      low_r     <= ent.low;
      high_r    <= ent.high;
      mk_r      <= mk_calc;
      p0_r      <= p0_calc;
      ones_r    <= ones;
      diff_lo_r <= diff[CNT_W-1:0];
      full_r    <= (diff >= 64'(WIN_LEN));
      lt_r      <= (ent.low < ent.high);
    end
  end

  // write-back stage
  logic [CNT_W-1:0]     adv;
  logic [WIN_LEN-1:0]   run_mask;
  logic [2*WIN_LEN-1:0] clr_wide;
  logic [WIN_LEN-1:0]   clr_mask;
  logic                 is_reset, is_apply, is_rel;
  logic                 grant;

  assign is_reset = (item_r.command == CMD_RESET);
  assign is_apply = (item_r.command == CMD_APPLY);
  assign is_rel   = (item_r.command == CMD_RELEASE);
  assign grant    = act_r && is_apply && !full_r;

  // advance stops at the high cursor
  always_comb begin
    if (!lt_r) begin
      adv = '0;
    end else if (full_r || (ones_r < diff_lo_r)) begin
      adv = ones_r;
    end else begin
      adv = diff_lo_r;
    end
  end

  assign run_mask = (adv == CNT_W'(WIN_LEN)) ? '1 : ((WIN_LEN'(1) << adv) - WIN_LEN'(1));
  assign clr_wide = {run_mask, run_mask} << p0_r;
  assign clr_mask = clr_wide[2*WIN_LEN-1:WIN_LEN];

  always_comb begin
    mem_wr.we   = (state_r == S_WB) && act_r && (is_reset || is_rel || grant);
    mem_wr.addr = widx_r;
    if (is_reset) begin
      mem_wr.data.low   = item_r.seq_number;
      mem_wr.data.high  = item_r.seq_number;
      mem_wr.data.marks = '0;
    end else if (is_apply) begin
      mem_wr.data.low   = low_r;
      mem_wr.data.high  = high_r + 64'd1;
      mem_wr.data.marks = mk_r;
    end else begin
      mem_wr.data.low   = low_r + 64'(adv);
      mem_wr.data.high  = high_r;
      mem_wr.data.marks = mk_r & ~clr_mask;
    end
  end

  // result register
  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (state_r == S_WB) begin
      if (rng_err_r) begin
        out_item_r.status <= ST_RANGE;
      end else if (act_r && is_apply && full_r) begin
        out_item_r.status <= ST_RETRY;
      end else begin
        out_item_r.status <= ST_OK;
      end
      out_item_r.granted_number <= grant ? (high_r + 64'd1) : '0;
      out_item_r.oldest_done    <= grant ? low_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_WB);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // sequencer
  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_CALC : S_IDLE;
      S_CALC:  state_nxt = S_WB;
      S_WB:    state_nxt = accept ? S_CALC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CALC))
    else $error("accepted item did not enter calc");

  a_result_follows_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |=> out_valid)
    else $error("write-back produced no result");

  a_result_only_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_WB))
    else $error("result without a write-back cycle");

  a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr.we) |-> (act_r && !rng_err_r))
    else $error("window written by an inactive item");

  a_retry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.granted_number == '0 && out_item.oldest_done == '0))
    else $error("non-ok result carries numbers");
`endif

endmodule

>>> dv/sequence_window_allocator_core_test.sv
// self-checking testbench for the sequence window allocator core
module sequence_window_allocator_core_test;
  import swa_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CHUNK = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [63:0]        low;
    logic [63:0]        high;
    logic [WIN_LEN-1:0] marks;
  } window_t;

  typedef struct packed {
    out_item_t res;
    window_t   win;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // register copies, shared by the planner and the checker (written only while idle)
  logic       cfg_en = 1'b1;
  logic [3:0] cfg_groups = 4'd8;
  logic [3:0] cfg_queues = 4'd8;

  window_t   model_win [NUM_WIN];
  window_t   plan_win [NUM_WIN];
  in_item_t  waiting_commands [$];
  out_item_t expected_answers [$];

  int queued_count = 0;
  int taken_count = 0;
  int mismatch_count = 0;
  int settings_count = 1;
  int grant_count = 0;
  int retry_count = 0;
  int range_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int cycle_count = 0;

  sequence_window_allocator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // answer and window update for one command
  function automatic step_t resolve_item(in_item_t it, logic en, logic [3:0] groups,
                                         logic [3:0] queues, window_t w);
    step_t            s;
    logic [63:0]      span;
    logic [POS_W-1:0] pos;
    s.res = '0;
    s.win = w;
    if (!en || it.command == CMD_SPARE) return s;
    if ({1'b0, it.group_index} >= groups || {1'b0, it.queue_index} >= queues) begin
      s.res.status = ST_RANGE;
      return s;
    end
    case (it.command)
      CMD_RESET: begin
        s.win.low = it.seq_number;
        s.win.high = it.seq_number;
        s.win.marks = '0;
      end
      CMD_APPLY: begin
        span = w.high - w.low;
        if (span < 64'(WIN_LEN)) begin
          s.win.high = w.high + 64'd1;
          s.res.granted_number = s.win.high;
          s.res.oldest_done = w.low;
        end else begin
          s.res.status = ST_RETRY;
        end
      end
      CMD_RELEASE: begin
        s.win.marks[it.seq_number[POS_W-1:0]] = 1'b1;
        // walk the low cursor over the run of finished numbers
        for (int k = 0; k <= WIN_LEN; k++) begin
          pos = s.win.low[POS_W-1:0] + 1'b1;
          if (s.win.low >= s.win.high || !s.win.marks[pos]) break;
          s.win.marks[pos] = 1'b0;
          s.win.low = s.win.low + 64'd1;
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // planner keeps its own window copy so it knows which numbers are open
  task automatic queue_command(logic [1:0] cmd, logic [2:0] g, logic [2:0] q,
                               logic [63:0] seq);
    in_item_t it;
    step_t    s;
    it.command = cmd;
    it.group_index = g;
    it.queue_index = q;
    it.seq_number = seq;
    s = resolve_item(it, cfg_en, cfg_groups, cfg_queues, plan_win[{g, q}]);
    plan_win[{g, q}] = s.win;
    waiting_commands.insert(waiting_commands.size(), it);
    queued_count++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      CFG_ENABLE: cfg_en = value[0];
      CFG_GROUPS: cfg_groups = value[3:0];
      CFG_QUEUES: cfg_queues = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic en, logic [3:0] groups, logic [3:0] queues);
    write_reg(CFG_ENABLE, {31'd0, en});
    write_reg(CFG_GROUPS, {28'd0, groups});
    write_reg(CFG_QUEUES, {28'd0, queues});
    settings_count++;
  endtask

  // hold the sender until every queued item is taken and answered or counted as missing
  task automatic drain();
    int waited;
    waited = 0;
    do @(negedge clk); while (taken_count != queued_count);
    while (expected_answers.size() != 0 && waited < 20) begin
      @(negedge clk);
      waited++;
    end
    if (expected_answers.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, expected_answers.size());
      mismatch_count += expected_answers.size();
      expected_answers.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic plan_traffic(int count, bit focus);
    logic [1:0]  cmd;
    logic [2:0]  g, q;
    logic [63:0] seq, span, off;
    window_t     w;
    int          gmax, qmax, roll, k;
    gmax = (cfg_groups > 4'(MAX_GROUPS)) ? MAX_GROUPS : int'(cfg_groups);
    qmax = (cfg_queues > 4'(MAX_QUEUES)) ? MAX_QUEUES : int'(cfg_queues);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      seq = {$urandom, $urandom};
      if (roll < 25 || gmax == 0 || qmax == 0 || !cfg_en) begin
        cmd = 2'($urandom_range(0, 3));
        g = 3'($urandom_range(0, 7));
        q = 3'($urandom_range(0, 7));
      end else begin
        if (focus) begin
          g = ($urandom_range(0, 1) == 1) ? 3'(gmax - 1) : 3'd0;
          q = 3'd0;
        end else begin
          g = 3'($urandom_range(0, gmax - 1));
          q = 3'($urandom_range(0, qmax - 1));
        end
        w = plan_win[{g, q}];
        span = w.high - w.low;
        if (roll < 31) begin
          cmd = CMD_RESET;
          case ($urandom_range(0, 2))
            0: seq = ~64'($urandom_range(0, 80));
            1: seq = 64'($urandom_range(0, 1000));
            default: ;
          endcase
        end else if (roll < (focus ? 80 : 62) || span == 0) begin
          cmd = CMD_APPLY;
        end else begin
          cmd = CMD_RELEASE;
          // pick an open number: granted but not yet finished
          off = 64'($urandom_range(0, 32'(span) - 1));
          for (k = 0; k < WIN_LEN; k++) begin
            seq = w.low + 64'd1 + off;
            if (!w.marks[seq[POS_W-1:0]]) break;
            off = (off + 64'd1) % span;
          end
          if ($urandom_range(0, 15) == 0) seq = seq + 64'(WIN_LEN);
        end
      end
      queue_command(cmd, g, q, seq);
      if (i % CHUNK == CHUNK - 1) drain();
    end
    drain();
  endtask

  always @(posedge clk) begin : drive_items
    step_t s;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        s = resolve_item(in_item, cfg_en, cfg_groups, cfg_queues,
                         model_win[{in_item.group_index, in_item.queue_index}]);
        model_win[{in_item.group_index, in_item.queue_index}] = s.win;
        expected_answers.insert(expected_answers.size(), s.res);
        taken_count++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (waiting_commands.size() > 0) begin
          start <= 1'b1;
          in_item <= waiting_commands.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left = $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(0, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_answers
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected answer status %0d granted %0h oldest %0h", $time,
                 out_item.status, out_item.granted_number, out_item.oldest_done);
        mismatch_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_item.status);
          mismatch_count++;
        end
        if (out_item.granted_number !== want.granted_number) begin
          $display("%0t: granted_number expected %0h got %0h", $time,
                   want.granted_number, out_item.granted_number);
          mismatch_count++;
        end
        if (out_item.oldest_done !== want.oldest_done) begin
          $display("%0t: oldest_done expected %0h got %0h", $time,
                   want.oldest_done, out_item.oldest_done);
          mismatch_count++;
        end
        if (want.status == ST_RETRY) retry_count++;
        if (want.status == ST_RANGE) range_count++;
        if (want.granted_number != 64'd0 || want.oldest_done != 64'd0) grant_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish in time", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_WIN; i++) begin
      model_win[i] = '0;
      plan_win[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // basic grant, out-of-order finish, then the low cursor catching up
    queue_command(CMD_RESET, 3'd0, 3'd0, 64'd0);
    queue_command(CMD_APPLY, 3'd0, 3'd0, '1);
    queue_command(CMD_APPLY, 3'd0, 3'd0, 64'd0);
    queue_command(CMD_APPLY, 3'd0, 3'd0, 64'd0);
    queue_command(CMD_RELEASE, 3'd0, 3'd0, 64'd2);
    queue_command(CMD_RELEASE, 3'd0, 3'd0, 64'd3);
    queue_command(CMD_RELEASE, 3'd0, 3'd0, 64'd1);
    queue_command(CMD_APPLY, 3'd0, 3'd0, 64'd0);
    // cursors wrapping past all ones
    queue_command(CMD_RESET, 3'd7, 3'd7, 64'hFFFF_FFFF_FFFF_FFFE);
    queue_command(CMD_APPLY, 3'd7, 3'd7, 64'd0);
    queue_command(CMD_APPLY, 3'd7, 3'd7, 64'd0);
    queue_command(CMD_RELEASE, 3'd7, 3'd7, 64'd0);
    queue_command(CMD_RELEASE, 3'd7, 3'd7, '1);
    // release far outside the window still sets its mark
    queue_command(CMD_RELEASE, 3'd0, 3'd0, 64'h8000_0000_0000_0047);
    queue_command(CMD_SPARE, 3'd7, 3'd7, 64'h5A5A_A5A5_0F0F_F0F0);
    // release on an untouched window, then a grant on that window
    queue_command(CMD_RELEASE, 3'd5, 3'd2, 64'd5);
    queue_command(CMD_APPLY, 3'd5, 3'd2, 64'd0);
    queue_command(CMD_RESET, 3'd3, 3'd4, '1);
    queue_command(CMD_APPLY, 3'd3, 3'd4, 64'd0);
    drain();

    set_config(1'b1, 4'd1, 4'd1);
    queue_command(CMD_APPLY, 3'd1, 3'd0, 64'd0);
    queue_command(CMD_APPLY, 3'd0, 3'd1, 64'd0);
    queue_command(CMD_RESET, 3'd0, 3'd0, 64'd10);
    queue_command(CMD_APPLY, 3'd0, 3'd0, 64'd0);
    plan_traffic(60, 1'b1);

    set_config(1'b1, 4'd8, 4'd8);
    plan_traffic(200, 1'b0);

    // fill one window past its length to force retries, across the wrap
    set_config(1'b1, 4'd2, 4'd8);
    queue_command(CMD_RESET, 3'd0, 3'd0, ~64'd20);
    for (int i = 0; i < WIN_LEN + 2; i++) queue_command(CMD_APPLY, 3'd0, 3'd0, 64'd0);
    plan_traffic(150, 1'b1);

    set_config(1'b0, 4'd8, 4'd8);
    plan_traffic(40, 1'b0);

    set_config(1'b1, 4'd0, 4'd4);
    plan_traffic(30, 1'b0);

    set_config(1'b1, 4'd15, 4'd15);
    plan_traffic(200, 1'b0);

    set_config(1'b1, 4'd3, 4'd5);
    plan_traffic(140, 1'b0);

    set_config(1'b1, 4'd8, 4'd1);
    plan_traffic(100, 1'b0);

    repeat (10) @(posedge clk);
    $display("%0d commands under %0d register settings", taken_count, settings_count);
    $display("%0d grants, %0d window-full retries, %0d range errors",
             grant_count, retry_count, range_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sequence_window_allocator_core.f
rtl/core/swa_pkg.sv
rtl/core/swa_win_store.sv
rtl/core/sequence_window_allocator_core.sv
dv/sequence_window_allocator_core_test.sv
